// ===== src/isk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isk_pkg
// Shared types and constants of the ini section key lookup block.
// ----------------------------------------------------------------------------
package isk_pkg;

  localparam int NAME_BYTES = 8;
  localparam int VALUE_MAX  = 63;
  localparam int NAME_W     = 64;
  localparam int LEN_W      = 4;
  localparam int OCC_W      = 8;
  localparam int VC_W       = $clog2(VALUE_MAX + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_SECTION_NAME       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTION_LENGTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTION_OCCURRENCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_NAME           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH         = 3'd4;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_LBR = 8'h5B;
  localparam logic [7:0] CH_RBR = 8'h5D;

  typedef enum logic [2:0] {
    PH_START        = 3'd0,
    PH_HDR_SCAN     = 3'd1,
    PH_HDR_NAME     = 3'd2,
    PH_REGION_FIRST = 3'd3,
    PH_KEY_SCAN     = 3'd4,
    PH_KEY_NAME     = 3'd5,
    PH_VALUE        = 3'd6,
    PH_WAIT         = 3'd7
  } phase_e;

  // classified text word
  typedef struct packed {
    logic [7:0] text;
    logic       last;
    logic       is_brk;
    logic       is_lbr;
    logic       is_rbr;
    logic       is_eq;
  } item_t;

  typedef struct packed {
    logic [NAME_W-1:0] section_name;
    logic [LEN_W-1:0]  section_length;
    logic [OCC_W-1:0]  section_occurrence;
    logic [NAME_W-1:0] key_name;
    logic [LEN_W-1:0]  key_length;
  } cfg_t;

endpackage
`default_nettype wire

// ===== src/isk_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isk_front
// Input side: takes text words and tags the bytes that steer the search.
// ----------------------------------------------------------------------------
module isk_front (
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    text_byte_i,
  input  wire logic          stream_end_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output isk_pkg::item_t     item_o
);
  import isk_pkg::*;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.text   = text_byte_i;
    item_o.last   = stream_end_i;
    item_o.is_brk = (text_byte_i == CH_LF) || (text_byte_i == CH_CR);
    item_o.is_lbr = (text_byte_i == CH_LBR);
    item_o.is_rbr = (text_byte_i == CH_RBR);
    item_o.is_eq  = (text_byte_i == CH_EQ);
  end

endmodule
`default_nettype wire

// ===== src/isk_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isk_queue
// Short word queue between the classifier and the search engine.
// ----------------------------------------------------------------------------
module isk_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire isk_pkg::item_t  item_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output isk_pkg::item_t       item_o
);
  import isk_pkg::*;

  item_t            mem_q [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [Q_AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [Q_AW:0]    count_q, count_d;

  assign full_o  = (count_q == (Q_AW+1)'(Q_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + (push_i ? Q_AW'(1) : Q_AW'(0));
    rd_ptr_d = rd_ptr_q + (pop_i ? Q_AW'(1) : Q_AW'(0));
    count_d  = count_q + ((Q_AW+1)'(push_i)) - ((Q_AW+1)'(pop_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

endmodule
`default_nettype wire

// ===== src/isk_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isk_back
// Search engine: walks header, key and value phases one word per cycle when
// a word is queued and output is free, holding results in an output register.
// ----------------------------------------------------------------------------
module isk_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire isk_pkg::cfg_t   cfg_i,
  input  wire logic            q_valid_i,
  input  wire isk_pkg::item_t  item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [7:0]           value_byte_o,
  output logic                 byte_present_o,
  output logic                 lookup_done_o,
  output logic                 key_found_o
);
  import isk_pkg::*;

  phase_e            phase_q, phase_d;
  logic [LEN_W-1:0]  mpos_q, mpos_d;
  logic              mfail_q, mfail_d;
  logic              als_q, als_d;
  logic [OCC_W-1:0]  occ_q, occ_d;
  logic [VC_W-1:0]   vcnt_q, vcnt_d;

  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              out_present_q, out_done_q, out_found_q;

  logic              res_n;
  logic [7:0]        res_byte;
  logic              res_present, res_done, res_found;
  logic              do_key, vdone;
  logic [LEN_W-1:0]  slen, klen;
  logic [7:0]        sbyte, kbyte;

  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  assign slen = (cfg_i.section_length > LEN_W'(NAME_BYTES)) ?
                LEN_W'(NAME_BYTES) : cfg_i.section_length;
  assign klen = (cfg_i.key_length > LEN_W'(NAME_BYTES)) ?
                LEN_W'(NAME_BYTES) : cfg_i.key_length;

  always_comb begin
    phase_d     = phase_q;
    mpos_d      = mpos_q;
    mfail_d     = mfail_q;
    als_d       = als_q;
    occ_d       = occ_q;
    vcnt_d      = vcnt_q;
    res_n       = 1'b0;
    res_byte    = '0;
    res_present = 1'b0;
    res_done    = 1'b0;
    res_found   = 1'b0;
    do_key      = 1'b0;
    vdone       = 1'b0;
    sbyte       = cfg_i.section_name[8*mpos_q[2:0] +: 8];
    kbyte       = '0;

    // first word of a stream
    if (phase_d == PH_START) begin
      occ_d   = cfg_i.section_occurrence;
      phase_d = PH_HDR_SCAN;
      als_d   = 1'b1;
      mfail_d = 1'b0;
    end

    case (phase_d)
      PH_HDR_SCAN: begin
        if (item_i.is_brk) begin
          als_d = 1'b1;
        end else if (als_d && item_i.is_lbr) begin
          phase_d = PH_HDR_NAME;
          mpos_d  = '0;
          als_d   = 1'b0;
        end else begin
          als_d = 1'b0;
        end
      end
      PH_HDR_NAME: begin
        if (item_i.is_brk) begin
          phase_d = PH_HDR_SCAN;
          als_d   = 1'b1;
        end else if (mpos_d < slen) begin
          if (item_i.text == sbyte) begin
            mpos_d = mpos_d + LEN_W'(1);
          end else begin
            phase_d = PH_HDR_SCAN;
            als_d   = 1'b0;
          end
        end else if (item_i.is_rbr) begin
          if (occ_d == '0) begin
            phase_d = PH_REGION_FIRST;
            als_d   = 1'b1;
          end else begin
            occ_d   = occ_d - OCC_W'(1);
            phase_d = PH_HDR_SCAN;
            als_d   = 1'b0;
          end
        end else begin
          phase_d = PH_HDR_SCAN;
          als_d   = 1'b0;
        end
      end
      PH_REGION_FIRST, PH_KEY_SCAN: begin
        if (item_i.is_brk) begin
          phase_d = PH_KEY_SCAN;
          als_d   = 1'b1;
        end else if (phase_d == PH_KEY_SCAN && !als_d) begin
          // rest of a non-matching line
        end else if (phase_d == PH_KEY_SCAN && item_i.is_lbr) begin
          phase_d = PH_WAIT;
          mfail_d = 1'b0;
        end else begin
          mpos_d = '0;
          do_key = 1'b1;
        end
      end
      PH_KEY_NAME: begin
        if (item_i.is_brk) begin
          phase_d = PH_KEY_SCAN;
          als_d   = 1'b1;
        end else begin
          do_key = 1'b1;
        end
      end
      PH_VALUE: begin
        if (item_i.is_brk) begin
          res_n     = 1'b1;
          res_done  = 1'b1;
          res_found = 1'b1;
          phase_d   = PH_WAIT;
          mfail_d   = 1'b1;
        end else begin
          vcnt_d      = vcnt_d + VC_W'(1);
          vdone       = (vcnt_d >= VC_W'(VALUE_MAX)) || item_i.last;
          res_n       = 1'b1;
          res_byte    = item_i.text;
          res_present = 1'b1;
          res_done    = vdone;
          res_found   = vdone;
          if (vdone) begin
            phase_d = PH_WAIT;
            mfail_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (do_key) begin
      kbyte = cfg_i.key_name[8*mpos_d[2:0] +: 8];
      if (mpos_d < klen) begin
        if (item_i.text == kbyte) begin
          mpos_d  = mpos_d + LEN_W'(1);
          phase_d = PH_KEY_NAME;
        end else begin
          phase_d = PH_KEY_SCAN;
        end
        als_d = 1'b0;
      end else if (item_i.is_eq) begin
        phase_d = PH_VALUE;
        vcnt_d  = '0;
      end else begin
        phase_d = PH_KEY_SCAN;
        als_d   = 1'b0;
      end
    end

    if (item_i.last) begin
      if (!res_n) begin
        if (phase_d == PH_VALUE) begin
          res_n     = 1'b1;
          res_done  = 1'b1;
          res_found = 1'b1;
        end else if (!(phase_d == PH_WAIT && mfail_d)) begin
          res_n    = 1'b1;
          res_done = 1'b1;
        end
      end
      phase_d = PH_START;
      mpos_d  = '0;
      mfail_d = 1'b0;
      als_d   = 1'b1;
      vcnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      mpos_q      <= '0;
      mfail_q     <= 1'b0;
      als_q       <= 1'b1;
      occ_q       <= '0;
      vcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q     <= phase_d;
        mpos_q      <= mpos_d;
        mfail_q     <= mfail_d;
        als_q       <= als_d;
        occ_q       <= occ_d;
        vcnt_q      <= vcnt_d;
        out_valid_q <= res_n;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && res_n) begin
      out_byte_q    <= res_byte;
      out_present_q <= res_present;
      out_done_q    <= res_done;
      out_found_q   <= res_found;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign value_byte_o   = out_byte_q;
  assign byte_present_o = out_present_q;
  assign lookup_done_o  = out_done_q;
  assign key_found_o    = out_found_q;

  a_mpos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mpos_q <= LEN_W'(NAME_BYTES))
    else $error("match position beyond name length");
  a_vcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_VALUE) |-> (vcnt_q < VC_W'(VALUE_MAX)))
    else $error("value count reached limit without finishing");
  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_found_q) |-> out_done_q)
    else $error("found flagged without done");
  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_START) |-> (mpos_q == '0 && vcnt_q == '0 && als_q))
    else $error("stream start with stale match state");

endmodule
`default_nettype wire

// ===== src/ini_section_key_lookup.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ini_section_key_lookup
// Streams INI text and returns the value of one key within one section.
// ----------------------------------------------------------------------------
// One text byte is taken per clock while the queue has room. Each byte is
// classified on entry and passes a four-word queue to the search engine, which
// handles one byte per cycle unless stalled; its result word is held in an
// output register, so input keeps flowing while the output is stalled until
// the queue fills. Value bytes come out one per word, and the word that ends
// the value is flagged done and found; with no match, the final byte of the
// stream yields a single done word with found low. Registers must be written
// through the plain write port between streams; the block does not enforce it.
module ini_section_key_lookup (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [isk_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [isk_pkg::NAME_W-1:0]         cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [7:0]                         text_byte_i,
  input  wire logic                               stream_end_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [7:0]                              value_byte_o,
  output logic                                    byte_present_o,
  output logic                                    lookup_done_o,
  output logic                                    key_found_o
);
  import isk_pkg::*;

  cfg_t   cfg_q;
  logic   push, pop, q_full, q_valid;
  item_t  front_item, q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SECTION_NAME:       cfg_q.section_name       <= cfg_data_i;
        CFG_SECTION_LENGTH:     cfg_q.section_length     <= cfg_data_i[LEN_W-1:0];
        CFG_SECTION_OCCURRENCE: cfg_q.section_occurrence <= cfg_data_i[OCC_W-1:0];
        CFG_KEY_NAME:           cfg_q.key_name           <= cfg_data_i;
        CFG_KEY_LENGTH:         cfg_q.key_length         <= cfg_data_i[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  isk_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_byte_i  (text_byte_i),
    .stream_end_i (stream_end_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .item_o       (front_item)
  );

  isk_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  isk_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .item_i         (q_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_byte_o   (value_byte_o),
    .byte_present_o (byte_present_o),
    .lookup_done_o  (lookup_done_o),
    .key_found_o    (key_found_o)
  );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ini_section_key_lookup. Generated INI text goes in
// one byte per word through the valid/stall input while a predictor follows
// each accepted byte and queues the value words it should cause; every word
// the block returns is checked field by field against the oldest one due.
// ----------------------------------------------------------------------------
module tb_top;
  import isk_pkg::*;

  localparam int TOTAL_ITEMS   = 1650;
  localparam int SETTLE_CYCLES = 16;    // pipeline plus queue depth, with margin
  localparam int LONG_HOLD     = 300;
  localparam int QUIET_LIMIT   = 3000;  // well above the long hold and phase gaps

  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } text_word_t;

  typedef struct packed {
    logic [7:0] vbyte;
    logic       present;
    logic       done;
    logic       found;
  } lookup_word_t;

  logic                 clk_i;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i    = '0;
  logic [NAME_W-1:0]    cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           text_byte_i  = '0;
  logic                 stream_end_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [7:0]           value_byte_o;
  logic                 byte_present_o;
  logic                 lookup_done_o;
  logic                 key_found_o;

  ini_section_key_lookup u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .stream_end_i   (stream_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_byte_o   (value_byte_o),
    .byte_present_o (byte_present_o),
    .lookup_done_o  (lookup_done_o),
    .key_found_o    (key_found_o)
  );

  // register copies as the bench last wrote them
  logic [NAME_W-1:0] sec_name_r = '0;
  logic [LEN_W-1:0]  sec_len_r  = '0;
  logic [OCC_W-1:0]  sec_occ_r  = '0;
  logic [NAME_W-1:0] key_name_r = '0;
  logic [LEN_W-1:0]  key_len_r  = '0;

  // predictor state
  phase_e           scan_phase  = PH_START;
  logic [LEN_W-1:0] name_pos    = '0;
  logic             lookup_over = 1'b0;
  logic             line_head   = 1'b1;
  logic [OCC_W-1:0] hdr_skips   = '0;
  logic [VC_W-1:0]  value_len   = '0;

  text_word_t   pending_text[$];
  lookup_word_t value_words_due[$];
  logic [7:0]   stream_bytes[$];

  int   items_queued  = 0;
  int   err_count     = 0;
  int   quiet_cycles  = 0;
  int   src_gap       = 0;
  int   sink_gap      = 0;
  int   sink_hold     = 0;
  logic sink_hold_req = 1'b0;
  logic idle_en       = 1'b1;
  logic text_taken    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] len);
    return (len > LEN_W'(NAME_BYTES)) ? LEN_W'(NAME_BYTES) : len;
  endfunction

  function automatic logic [7:0] name_byte(logic [NAME_W-1:0] nm, logic [LEN_W-1:0] i);
    return nm[{i[2:0], 3'b000} +: 8];
  endfunction

  // one byte of a key compare, entered at a line start or mid-key
  function automatic void match_key_byte(logic [7:0] b);
    if (name_pos < clamp_len(key_len_r)) begin
      if (b == name_byte(key_name_r, name_pos)) begin
        name_pos   = name_pos + 1'b1;
        scan_phase = PH_KEY_NAME;
      end else begin
        scan_phase = PH_KEY_SCAN;
      end
      line_head = 1'b0;
    end else if (b == CH_EQ) begin
      scan_phase = PH_VALUE;
      value_len  = '0;
    end else begin
      scan_phase = PH_KEY_SCAN;
      line_head  = 1'b0;
    end
  endfunction

  function automatic void step_value_search(logic [7:0] b, logic last);
    lookup_word_t word;
    logic         emitted;
    logic         brk;
    logic         full;
    emitted = 1'b0;
    word    = '0;
    brk     = (b == CH_LF) || (b == CH_CR);
    if (scan_phase == PH_START) begin
      hdr_skips   = sec_occ_r;
      scan_phase  = PH_HDR_SCAN;
      line_head   = 1'b1;
      lookup_over = 1'b0;
    end
    case (scan_phase)
      PH_HDR_SCAN: begin
        if (brk) begin
          line_head = 1'b1;
        end else if (line_head && b == CH_LBR) begin
          scan_phase = PH_HDR_NAME;
          name_pos   = '0;
          line_head  = 1'b0;
        end else begin
          line_head = 1'b0;
        end
      end
      PH_HDR_NAME: begin
        if (brk) begin
          scan_phase = PH_HDR_SCAN;
          line_head  = 1'b1;
        end else if (name_pos < clamp_len(sec_len_r)) begin
          if (b == name_byte(sec_name_r, name_pos)) begin
            name_pos = name_pos + 1'b1;
          end else begin
            scan_phase = PH_HDR_SCAN;
            line_head  = 1'b0;
          end
        end else if (b == CH_RBR) begin
          if (hdr_skips == '0) begin
            scan_phase = PH_REGION_FIRST;
            line_head  = 1'b1;
          end else begin
            hdr_skips  = hdr_skips - 1'b1;
            scan_phase = PH_HDR_SCAN;
            line_head  = 1'b0;
          end
        end else begin
          scan_phase = PH_HDR_SCAN;
          line_head  = 1'b0;
        end
      end
      PH_REGION_FIRST, PH_KEY_SCAN: begin
        if (brk) begin
          scan_phase = PH_KEY_SCAN;
          line_head  = 1'b1;
        end else if (scan_phase == PH_KEY_SCAN && !line_head) begin
          // rest of the line is skipped
        end else if (scan_phase == PH_KEY_SCAN && b == CH_LBR) begin
          scan_phase  = PH_WAIT;
          lookup_over = 1'b0;
        end else begin
          name_pos = '0;
          match_key_byte(b);
        end
      end
      PH_KEY_NAME: begin
        if (brk) begin
          scan_phase = PH_KEY_SCAN;
          line_head  = 1'b1;
        end else begin
          match_key_byte(b);
        end
      end
      PH_VALUE: begin
        if (brk) begin
          word        = {8'h00, 1'b0, 1'b1, 1'b1};
          emitted     = 1'b1;
          scan_phase  = PH_WAIT;
          lookup_over = 1'b1;
        end else begin
          value_len = value_len + 1'b1;
          full      = (int'(value_len) >= VALUE_MAX) || last;
          word      = {b, 1'b1, full, full};
          emitted   = 1'b1;
          if (full) begin
            scan_phase  = PH_WAIT;
            lookup_over = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (last) begin
      if (!emitted) begin
        if (scan_phase == PH_VALUE) begin
          word    = {8'h00, 1'b0, 1'b1, 1'b1};
          emitted = 1'b1;
        end else if (!(scan_phase == PH_WAIT && lookup_over)) begin
          word    = {8'h00, 1'b0, 1'b1, 1'b0};
          emitted = 1'b1;
        end
      end
      scan_phase  = PH_START;
      name_pos    = '0;
      lookup_over = 1'b0;
      line_head   = 1'b1;
      value_len   = '0;
    end
    if (emitted) value_words_due.push_back(word);
  endfunction

  // mostly a..c so that partial matches are common, now and then any byte or a break
  function automatic logic [7:0] name_char();
    case ($urandom_range(0, 31))
      0: return 8'($urandom);
      1: return CH_LF;
      default: return 8'h61 + 8'($urandom_range(0, 2));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return LEN_W'($urandom_range(NAME_BYTES + 1, 15));
      default: return LEN_W'($urandom_range(1, NAME_BYTES));
    endcase
  endfunction

  function automatic void add_name(logic [NAME_W-1:0] nm, logic [LEN_W-1:0] len);
    for (int i = 0; i < int'(clamp_len(len)); i++) stream_bytes.push_back(nm[8*i +: 8]);
  endfunction

  // damage one spot of the line built so far
  function automatic void spoil(int line_from);
    int at;
    if (stream_bytes.size() <= line_from) return;
    at = $urandom_range(line_from, stream_bytes.size() - 1);
    case ($urandom_range(0, 2))
      0: stream_bytes[at] = stream_bytes[at] ^ 8'h01;
      1: stream_bytes.delete(at);
      default: stream_bytes.insert(at, name_char());
    endcase
  endfunction

  // a few lines of INI text built around the current section and key
  function automatic void build_stream();
    int n_lines;
    int line_from;
    int sel;
    int n;
    int keep;
    stream_bytes.delete();
    n_lines = $urandom_range(1, 8);
    repeat (n_lines) begin
      line_from = stream_bytes.size();
      // a leading blank hides a header or a key
      if ($urandom_range(0, 7) == 0) stream_bytes.push_back(8'h20);
      sel = $urandom_range(0, 11);
      if (sel < 4) begin
        stream_bytes.push_back(CH_LBR);
        add_name(sec_name_r, sec_len_r);
        stream_bytes.push_back(CH_RBR);
        if (sel == 3) spoil(line_from);
        if ($urandom_range(0, 3) == 0) stream_bytes.push_back(name_char());
      end else if (sel < 9) begin
        add_name(key_name_r, key_len_r);
        stream_bytes.push_back(CH_EQ);
        if (sel == 8) spoil(line_from);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(VALUE_MAX - 8, VALUE_MAX + 12)
                                        : $urandom_range(0, 6);
        repeat (n) begin
          stream_bytes.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(33, 126)));
        end
      end else if (sel == 9) begin
        repeat ($urandom_range(1, 10)) stream_bytes.push_back(8'($urandom));
      end else if (sel == 11) begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0: stream_bytes.push_back(CH_EQ);
            1: stream_bytes.push_back(CH_LBR);
            default: stream_bytes.push_back(name_char());
          endcase
        end
      end
      case ($urandom_range(0, 5))
        0, 1: stream_bytes.push_back(CH_LF);
        2: stream_bytes.push_back(CH_CR);
        3: begin
          stream_bytes.push_back(CH_CR);
          stream_bytes.push_back(CH_LF);
        end
        4: begin
          stream_bytes.push_back(CH_LF);
          stream_bytes.push_back(CH_LF);
        end
        default: begin
          // runs straight into the next line
        end
      endcase
    end
    // cut short, possibly inside a header or key compare
    if ($urandom_range(0, 5) == 0 && stream_bytes.size() > 1) begin
      keep = $urandom_range(1, stream_bytes.size());
      while (stream_bytes.size() > keep) void'(stream_bytes.pop_back());
    end
    if (stream_bytes.size() == 0) stream_bytes.push_back(name_char());
  endfunction

  function automatic void push_byte(logic [7:0] b, logic closes);
    pending_text.push_back({b, closes});
    items_queued++;
  endfunction

  function automatic void push_text(string s, logic closes);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], closes && i == s.len() - 1);
  endfunction

  function automatic void send_stream(int from, int upto, logic closes);
    for (int i = from; i < upto; i++) push_byte(stream_bytes[i], closes && i == upto - 1);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NAME_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_SECTION_NAME:       sec_name_r = data;
      CFG_SECTION_LENGTH:     sec_len_r  = data[LEN_W-1:0];
      CFG_SECTION_OCCURRENCE: sec_occ_r  = data[OCC_W-1:0];
      CFG_KEY_NAME:           key_name_r = data;
      CFG_KEY_LENGTH:         key_len_r  = data[LEN_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input logic [NAME_W-1:0] snm, input logic [LEN_W-1:0] slen,
                            input logic [OCC_W-1:0] socc, input logic [NAME_W-1:0] knm,
                            input logic [LEN_W-1:0] klen);
    logic [NAME_W-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(CFG_SECTION_NAME, snm);
    write_reg(CFG_SECTION_LENGTH, {junk[NAME_W-1:LEN_W], slen});
    write_reg(CFG_SECTION_OCCURRENCE, {junk[NAME_W-1:OCC_W], socc});
    write_reg(CFG_KEY_NAME, knm);
    write_reg(CFG_KEY_LENGTH, {junk[NAME_W-1:LEN_W], klen});
    // spare indexes must leave every register alone
    for (int i = int'(CFG_KEY_LENGTH) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), {$urandom, $urandom});
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // all words sent and all results back, then let the pipe empty
  task automatic wait_idle();
    while (pending_text.size() != 0 || in_valid_i || value_words_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // input side: a new word only once the previous one has been taken
  always @(negedge clk_i) begin : drive_text
    text_word_t nxt;
    if (rst_ni && (!in_valid_i || text_taken)) begin
      text_taken = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
        in_valid_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        src_gap = $urandom_range(0, 14);
        in_valid_i <= 1'b0;
      end else if (pending_text.size() > 0) begin
        nxt = pending_text.pop_front();
        in_valid_i   <= 1'b1;
        text_byte_i  <= nxt.text;
        stream_end_i <= nxt.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : take_text
    if (rst_ni && in_valid_i && !in_stall_o) begin
      step_value_search(text_byte_i, stream_end_i);
      text_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin : drive_stall
    if (sink_hold_req) begin
      sink_hold_req = 1'b0;
      sink_hold     = LONG_HOLD;
    end
    if (sink_hold > 0) begin
      sink_hold--;
      out_stall_i <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      sink_gap = $urandom_range(0, 14);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_words
    lookup_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (value_words_due.size() == 0) begin
        if (err_count < 10) begin
          $display("unexpected word: byte %02h present %b done %b found %b",
                   value_byte_o, byte_present_o, lookup_done_o, key_found_o);
        end
        err_count++;
      end else begin
        want = value_words_due.pop_front();
        if (value_byte_o !== want.vbyte || byte_present_o !== want.present ||
            lookup_done_o !== want.done || key_found_o !== want.found) begin
          if (err_count < 10) begin
            $display("mismatch: expected byte %02h present %b done %b found %b, got %02h %b %b %b",
                     want.vbyte, want.present, want.done, want.found,
                     value_byte_o, byte_present_o, lookup_done_o, key_found_o);
          end
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int               phase_no;
    int               n_streams;
    int               half;
    logic [NAME_W-1:0] snm;
    logic [NAME_W-1:0] knm;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // section "ab", key "k"
    set_config(64'h6261, 4'd2, 8'd0, 64'h6B, 4'd1);
    push_text("[ab]", 1'b0);
    push_byte(CH_CR, 1'b0);
    push_byte(CH_LF, 1'b0);
    push_text("k=vw", 1'b0);
    push_byte(CH_LF, 1'b1);
    // empty value closed by the end of the stream
    push_text("[ab]k=", 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    // region ends at the next header line before any key
    push_text("[ab]", 1'b0);
    push_byte(CH_LF, 1'b0);
    push_text("[", 1'b1);
    wait_idle();

    phase_no = 0;
    while (items_queued < TOTAL_ITEMS) begin
      phase_no++;
      if (phase_no == 1) begin
        set_config('1, 4'hF, 8'd0, '0, 4'd0);
      end else if (phase_no == 2) begin
        set_config('0, 4'd0, 8'hFF, '1, 4'd8);
      end else begin
        for (int i = 0; i < NAME_BYTES; i++) begin
          snm[8*i +: 8] = name_char();
          knm[8*i +: 8] = name_char();
        end
        set_config(snm, pick_len(),
                   ($urandom_range(0, 7) == 0) ? OCC_W'($urandom_range(3, 255))
                                               : OCC_W'($urandom_range(0, 2)),
                   knm, pick_len());
      end
      if (items_queued > TOTAL_ITEMS * 17 / 20) idle_en = 1'b0;
      // receiver holds off while the sender keeps offering
      if (phase_no == 3) sink_hold_req = 1'b1;
      n_streams = (phase_no == 2) ? 2 : 5;
      for (int s = 0; s < n_streams; s++) begin
        build_stream();
        if (phase_no == 4 && s == 0 && stream_bytes.size() > 1) begin
          // sender pauses mid-stream until everything due has come back
          half = stream_bytes.size() / 2;
          send_stream(0, half, 1'b0);
          wait_idle();
          send_stream(half, stream_bytes.size(), 1'b1);
        end else begin
          send_stream(0, stream_bytes.size(), 1'b1);
        end
      end
      wait_idle();
    end

    wait_idle();
    if (err_count == 0 && value_words_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
